// File: sv/bnep_pkg.sv
package bnep_pkg;

   localparam logic [7:0] CODE_DIGIT_LO  = 8'h10;
   localparam logic [7:0] CODE_DIGIT_HI  = 8'h19;
   localparam logic [7:0] CODE_POINT     = 8'h1A;
   localparam logic [7:0] CODE_EXP_ENTER = 8'h1B;
   localparam logic [7:0] CODE_CHG_SIGN  = 8'h1C;

   localparam int RUN_W   = 12;
   localparam int ACCUM_W = 10;
   localparam int EXP_W   = 13;
   localparam int MANT_W  = 40;
   localparam int OUT_DIGITS = 10;

   localparam logic signed [RUN_W-1:0] RUN_MAX   = 12'sh7FF;
   localparam logic signed [RUN_W-1:0] RUN_MIN   = 12'sh800;
   localparam logic signed [RUN_W-1:0] RUN_RESET = -12'sd1;
   localparam logic [ACCUM_W-1:0]      ACCUM_MAX = 10'd999;
   localparam logic signed [EXP_W-1:0] EXP_LIMIT = 13'sd99;
   localparam logic [7:0]              COUNT_MAX = 8'hFF;

   localparam logic [3:0] SIGN_POS = 4'd0;
   localparam logic [3:0] SIGN_NEG = 4'd9;

   typedef enum logic [2:0] {
      OP_DIGIT,
      OP_POINT,
      OP_EXP_ENTER,
      OP_CHG_SIGN,
      OP_TERM
   } op_kind_type;

   typedef struct packed {
      op_kind_type kind;
      logic [3:0]  digit;
   } op_type;

   typedef struct packed {
      logic signed [EXP_W-1:0] exp_val;
      logic                    mant_neg;
      logic [MANT_W-1:0]       mant;
      logic [7:0]              count;
   } result_type;

   // two BCD digits of a value below 100; tens by reciprocal multiply
   function automatic logic [7:0] bin_to_bcd2(input logic [6:0] mag);
      logic [14:0] prod;
      logic [3:0]  tens;
      logic [6:0]  tens_x10;
      logic [6:0]  ones;
      prod     = 15'(mag) * 15'd205;
      tens     = prod[14:11];
      tens_x10 = 7'({tens, 3'b000}) + 7'({tens, 1'b0});
      ones     = mag - tens_x10;
      return {tens, ones[3:0]};
   endfunction

endpackage

// File: sv/bnep_front.sv
module bnep_front (
   input  logic             req_valid,
   input  logic [7:0]       req_prog_byte,
   input  logic             queue_full,
   output logic             req_stall,
   output logic             push,
   output bnep_pkg::op_type push_op
);

   assign req_stall = queue_full;
   assign push      = req_valid && !queue_full;

   always_comb begin
      push_op.digit = req_prog_byte[3:0];
      if (req_prog_byte inside {[bnep_pkg::CODE_DIGIT_LO:bnep_pkg::CODE_DIGIT_HI]}) begin
         push_op.kind = bnep_pkg::OP_DIGIT;
      end else begin
         case (req_prog_byte)
            bnep_pkg::CODE_POINT:     push_op.kind = bnep_pkg::OP_POINT;
            bnep_pkg::CODE_EXP_ENTER: push_op.kind = bnep_pkg::OP_EXP_ENTER;
            bnep_pkg::CODE_CHG_SIGN:  push_op.kind = bnep_pkg::OP_CHG_SIGN;
            default:                  push_op.kind = bnep_pkg::OP_TERM;
         endcase
      end
   end

endmodule

// File: sv/bnep_queue.sv
module bnep_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  bnep_pkg::op_type push_op,
   input  logic             pop,
   output logic             full,
   output logic             head_valid,
   output bnep_pkg::op_type head_op
);

   bnep_pkg::op_type entries_ff [2];
   logic             wr_ptr_ff;
   logic             rd_ptr_ff;
   logic [1:0]       count_ff;
   logic [1:0]       count_in;

   assign full       = (count_ff == 2'd2);
   assign head_valid = (count_ff != 2'd0);
   assign head_op    = entries_ff[rd_ptr_ff];

   always_comb begin
      case ({push, pop})
         2'b10:   count_in = count_ff + 2'd1;
         2'b01:   count_in = count_ff - 2'd1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) wr_ptr_ff <= !wr_ptr_ff;
         if (pop)  rd_ptr_ff <= !rd_ptr_ff;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) entries_ff[wr_ptr_ff] <= push_op;
   end

endmodule

// File: sv/bnep_exec.sv
module bnep_exec #(
   parameter int MANT_DIGITS = 10
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 head_valid,
   input  bnep_pkg::op_type     head_op,
   input  logic                 fmt_stall,
   output logic                 pop,
   output logic                 res_valid,
   output bnep_pkg::result_type res
);

   localparam int CNT_W = $clog2(MANT_DIGITS + 1);

   typedef enum logic [1:0] {
      MODE_ZERO,
      MODE_MANT,
      MODE_EXP
   } mode_type;

   mode_type                               mode_ff, mode_in, mode_now;
   logic                                   point_ff, point_in;
   logic [CNT_W-1:0]                       dcount_ff, dcount_in;
   logic [3:0]                             digits_ff [MANT_DIGITS];
   logic [3:0]                             digits_in [MANT_DIGITS];
   logic signed [bnep_pkg::RUN_W-1:0]      run_ff, run_in, run_inc, run_dec;
   logic [bnep_pkg::ACCUM_W-1:0]           accum_ff, accum_in, accum_next;
   logic [13:0]                            accum_prod;
   logic                                   mant_neg_ff, mant_neg_in;
   logic                                   exp_neg_ff, exp_neg_in;
   logic [7:0]                             count_ff, count_in;
   logic [bnep_pkg::MANT_W-1:0]            mant_w;
   logic signed [bnep_pkg::EXP_W-1:0]      run_ext, accum_ext;

   assign pop       = head_valid && !fmt_stall;
   assign res_valid = head_valid && (head_op.kind == bnep_pkg::OP_TERM) && (count_ff != 8'd0);

   assign run_inc = (run_ff == bnep_pkg::RUN_MAX) ? run_ff : run_ff + 12'sd1;
   assign run_dec = (run_ff == bnep_pkg::RUN_MIN) ? run_ff : run_ff - 12'sd1;

   assign accum_prod = 14'({accum_ff, 3'b000}) + 14'({accum_ff, 1'b0}) + 14'(head_op.digit);
   assign accum_next = (accum_prod > 14'(bnep_pkg::ACCUM_MAX)) ? bnep_pkg::ACCUM_MAX
                                                               : accum_prod[9:0];

   // first ten stored digits, leading digit in the top nibble
   for (genvar g = 0; g < bnep_pkg::OUT_DIGITS; g++) begin : g_mant
      if (g < MANT_DIGITS) begin : g_used
         assign mant_w[(bnep_pkg::OUT_DIGITS-1-g)*4 +: 4] = digits_ff[g];
      end else begin : g_pad
         assign mant_w[(bnep_pkg::OUT_DIGITS-1-g)*4 +: 4] = 4'd0;
      end
   end

   assign run_ext   = $signed({run_ff[bnep_pkg::RUN_W-1], run_ff});
   assign accum_ext = $signed({3'b000, accum_ff});

   always_comb begin
      res.exp_val  = exp_neg_ff ? run_ext - accum_ext : run_ext + accum_ext;
      res.mant_neg = mant_neg_ff;
      res.mant     = mant_w;
      res.count    = count_ff;
   end

   always_comb begin
      mode_in     = mode_ff;
      mode_now    = mode_ff;
      point_in    = point_ff;
      dcount_in   = dcount_ff;
      digits_in   = digits_ff;
      run_in      = run_ff;
      accum_in    = accum_ff;
      mant_neg_in = mant_neg_ff;
      exp_neg_in  = exp_neg_ff;
      count_in    = count_ff;
      if (pop) begin
         case (head_op.kind)
            bnep_pkg::OP_DIGIT: begin
               // a nonzero digit ends the leading zeros
               if (mode_ff == MODE_ZERO && head_op.digit != 4'd0) mode_now = MODE_MANT;
               mode_in = mode_now;
               case (mode_now)
                  MODE_MANT: begin
                     if (dcount_ff < CNT_W'(MANT_DIGITS)) begin
                        for (int i = 0; i < MANT_DIGITS; i++) begin
                           if (dcount_ff == CNT_W'(i)) digits_in[i] = head_op.digit;
                        end
                        dcount_in = dcount_ff + CNT_W'(1);
                     end
                     if (!point_ff) run_in = run_inc;
                  end
                  MODE_EXP: accum_in = accum_next;
                  default: begin
                     if (point_ff) run_in = run_dec;
                  end
               endcase
            end
            bnep_pkg::OP_POINT: begin
               if (mode_ff != MODE_EXP) point_in = 1'b1;
            end
            bnep_pkg::OP_EXP_ENTER: begin
               if (mode_ff != MODE_EXP) begin
                  mode_in  = MODE_EXP;
                  accum_in = '0;
                  if (digits_ff[0] == 4'd0) digits_in[0] = 4'd1;
               end
            end
            bnep_pkg::OP_CHG_SIGN: begin
               if (mode_ff == MODE_MANT) mant_neg_in = !mant_neg_ff;
               else                      exp_neg_in  = !exp_neg_ff;
            end
            default: begin
               // terminator: drop everything once a number was started
               if (count_ff != 8'd0) begin
                  mode_in     = MODE_ZERO;
                  point_in    = 1'b0;
                  dcount_in   = '0;
                  for (int i = 0; i < MANT_DIGITS; i++) digits_in[i] = 4'd0;
                  run_in      = bnep_pkg::RUN_RESET;
                  accum_in    = '0;
                  mant_neg_in = 1'b0;
                  exp_neg_in  = 1'b0;
                  count_in    = 8'd0;
               end
            end
         endcase
         if (head_op.kind != bnep_pkg::OP_TERM && count_ff != bnep_pkg::COUNT_MAX) begin
            count_in = count_ff + 8'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= MODE_ZERO;
         point_ff    <= 1'b0;
         dcount_ff   <= '0;
         for (int i = 0; i < MANT_DIGITS; i++) digits_ff[i] <= 4'd0;
         run_ff      <= bnep_pkg::RUN_RESET;
         accum_ff    <= '0;
         mant_neg_ff <= 1'b0;
         exp_neg_ff  <= 1'b0;
         count_ff    <= 8'd0;
      end else begin
         mode_ff     <= mode_in;
         point_ff    <= point_in;
         dcount_ff   <= dcount_in;
         digits_ff   <= digits_in;
         run_ff      <= run_in;
         accum_ff    <= accum_in;
         mant_neg_ff <= mant_neg_in;
         exp_neg_ff  <= exp_neg_in;
         count_ff    <= count_in;
      end
   end

`ifndef SYNTHESIS
   a_dcount_bound: assert property (@(posedge clock) disable iff (reset)
      dcount_ff <= CNT_W'(MANT_DIGITS))
      else $error("digit count past mantissa length");

   a_accum_bound: assert property (@(posedge clock) disable iff (reset)
      accum_ff <= bnep_pkg::ACCUM_MAX)
      else $error("exponent accumulator past saturation");

   a_exp_lead: assert property (@(posedge clock) disable iff (reset)
      mode_ff == MODE_EXP |-> digits_ff[0] != 4'd0)
      else $error("exponent mode with zero leading digit");

   a_zero_mode: assert property (@(posedge clock) disable iff (reset)
      mode_ff == MODE_ZERO |-> dcount_ff == '0)
      else $error("digits stored in leading zero mode");

   a_clear_after: assert property (@(posedge clock) disable iff (reset)
      pop && res_valid |=> count_ff == 8'd0 && mode_ff == MODE_ZERO && !point_ff)
      else $error("state not cleared after a number");
`endif

endmodule

// File: sv/bnep_format.sv
module bnep_format (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 res_valid,
   input  bnep_pkg::result_type res,
   output logic                 fmt_stall,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic                 rsp_range_error,
   output logic [3:0]           rsp_mant_sign,
   output logic [39:0]          rsp_mant_bcd,
   output logic [3:0]           rsp_exp_sign,
   output logic [7:0]           rsp_exp_bcd,
   output logic [7:0]           rsp_bytes_used
);

   logic                              a_valid_ff;
   bnep_pkg::result_type              a_ff;
   logic                              rsp_valid_ff;
   logic                              range_ff, range_in;
   logic [3:0]                        mant_sign_ff, mant_sign_in;
   logic [39:0]                       mant_ff, mant_in;
   logic [3:0]                        exp_sign_ff, exp_sign_in;
   logic [7:0]                        exp_bcd_ff, exp_bcd_in;
   logic [7:0]                        used_ff;
   logic                              b_adv, a_take;
   logic signed [bnep_pkg::EXP_W-1:0] mag_full;

   assign b_adv     = !rsp_valid_ff || !rsp_stall;
   assign a_take    = !a_valid_ff || b_adv;
   assign fmt_stall = !a_take;

   assign mag_full = a_ff.exp_val[bnep_pkg::EXP_W-1] ? -a_ff.exp_val : a_ff.exp_val;

   always_comb begin
      range_in = (a_ff.exp_val > bnep_pkg::EXP_LIMIT) || (a_ff.exp_val < -bnep_pkg::EXP_LIMIT);
      if (range_in) begin
         mant_sign_in = bnep_pkg::SIGN_POS;
         mant_in      = '0;
         exp_sign_in  = bnep_pkg::SIGN_POS;
         exp_bcd_in   = 8'd0;
      end else begin
         mant_sign_in = a_ff.mant_neg ? bnep_pkg::SIGN_NEG : bnep_pkg::SIGN_POS;
         mant_in      = a_ff.mant;
         exp_sign_in  = a_ff.exp_val[bnep_pkg::EXP_W-1] ? bnep_pkg::SIGN_NEG : bnep_pkg::SIGN_POS;
         exp_bcd_in   = bnep_pkg::bin_to_bcd2(mag_full[6:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (a_take) a_valid_ff   <= res_valid;
         if (b_adv)  rsp_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (a_take && res_valid) a_ff <= res;
      if (b_adv && a_valid_ff) begin
         range_ff     <= range_in;
         mant_sign_ff <= mant_sign_in;
         mant_ff      <= mant_in;
         exp_sign_ff  <= exp_sign_in;
         exp_bcd_ff   <= exp_bcd_in;
         used_ff      <= a_ff.count;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_range_error = range_ff;
   assign rsp_mant_sign   = mant_sign_ff;
   assign rsp_mant_bcd    = mant_ff;
   assign rsp_exp_sign    = exp_sign_ff;
   assign rsp_exp_bcd     = exp_bcd_ff;
   assign rsp_bytes_used  = used_ff;

endmodule

// File: sv/bcd_number_entry_parser.sv
// Throughput: one program byte per cycle while the result side does not stall.
// A terminator byte passes through the queue slot, the result stage and the output
// stage before rsp_valid rises and its result can be taken.
// Bytes that do not end a number produce no result.
// Reset (synchronous, active high) empties the queue and the output stages and
// returns the entry state to leading-zero mode with exponent -1.
module bcd_number_entry_parser #(
   parameter int MANT_DIGITS = 10
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_prog_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_range_error,
   output logic [3:0]  rsp_mant_sign,
   output logic [39:0] rsp_mant_bcd,
   output logic [3:0]  rsp_exp_sign,
   output logic [7:0]  rsp_exp_bcd,
   output logic [7:0]  rsp_bytes_used
);

   logic                 push, pop, queue_full, head_valid, fmt_stall, res_valid;
   bnep_pkg::op_type     push_op, head_op;
   bnep_pkg::result_type res;

   bnep_front u_front (
      .req_valid     (req_valid),
      .req_prog_byte (req_prog_byte),
      .queue_full    (queue_full),
      .req_stall     (req_stall),
      .push          (push),
      .push_op       (push_op)
   );

   bnep_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_op    (push_op),
      .pop        (pop),
      .full       (queue_full),
      .head_valid (head_valid),
      .head_op    (head_op)
   );

   bnep_exec #(
      .MANT_DIGITS (MANT_DIGITS)
   ) u_exec (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_op    (head_op),
      .fmt_stall  (fmt_stall),
      .pop        (pop),
      .res_valid  (res_valid),
      .res        (res)
   );

   bnep_format u_format (
      .clock           (clock),
      .reset           (reset),
      .res_valid       (res_valid),
      .res             (res),
      .fmt_stall       (fmt_stall),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_range_error (rsp_range_error),
      .rsp_mant_sign   (rsp_mant_sign),
      .rsp_mant_bcd    (rsp_mant_bcd),
      .rsp_exp_sign    (rsp_exp_sign),
      .rsp_exp_bcd     (rsp_exp_bcd),
      .rsp_bytes_used  (rsp_bytes_used)
   );

endmodule

// File: tb/tb_top.sv
module tb_top;

   localparam int MANT_DIGITS    = 10;
   localparam int NUM_ITEMS      = 900;
   localparam int IDLE_PCT       = 21;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES   = 8;
   localparam int LONG_RUN       = 260;

   typedef struct packed {
      logic        range_error;
      logic [3:0]  mant_sign;
      logic [39:0] mant_bcd;
      logic [3:0]  exp_sign;
      logic [7:0]  exp_bcd;
      logic [7:0]  bytes_used;
   } number_type;

   typedef enum logic [1:0] {
      MODE_LEAD,
      MODE_MANT,
      MODE_EXPO
   } entry_mode_type;

   class entry_scoreboard;
      entry_mode_type mode;
      bit             point_seen;
      int             digit_count;
      logic [3:0]     digits [MANT_DIGITS];
      int             run_exp;
      int             accum;
      bit             mant_neg;
      bit             exp_neg;
      int             byte_count;
      number_type     expected_numbers [$];
      int unsigned    mismatches;

      function new();
         mismatches = 0;
         clear();
      endfunction

      function void clear();
         mode        = MODE_LEAD;
         point_seen  = 0;
         digit_count = 0;
         foreach (digits[i]) digits[i] = 4'd0;
         run_exp     = int'(bnep_pkg::RUN_RESET);
         accum       = 0;
         mant_neg    = 0;
         exp_neg     = 0;
         byte_count  = 0;
      endfunction

      function void shift_exp(int delta);
         run_exp = run_exp + delta;
         if (run_exp > int'(bnep_pkg::RUN_MAX)) run_exp = int'(bnep_pkg::RUN_MAX);
         if (run_exp < int'(bnep_pkg::RUN_MIN)) run_exp = int'(bnep_pkg::RUN_MIN);
      endfunction

      // advance the entry state by one accepted byte; a terminator after an entry code yields a number
      function void note_byte(logic [7:0] b);
         int         e;
         int         mag;
         int         lim;
         int         sum;
         logic [3:0] d;
         number_type n;
         lim = int'(bnep_pkg::EXP_LIMIT);
         if (b >= bnep_pkg::CODE_DIGIT_LO && b <= bnep_pkg::CODE_CHG_SIGN) begin
            if (b <= bnep_pkg::CODE_DIGIT_HI) begin
               d = 4'(b - bnep_pkg::CODE_DIGIT_LO);
               if (mode == MODE_LEAD && d != 4'd0) mode = MODE_MANT;
               if (mode == MODE_MANT) begin
                  if (digit_count < MANT_DIGITS) begin
                     digits[digit_count] = d;
                     digit_count++;
                  end
                  if (!point_seen) shift_exp(1);
               end else if (mode == MODE_EXPO) begin
                  sum   = accum * 10 + int'(d);
                  accum = (sum > int'(bnep_pkg::ACCUM_MAX)) ? int'(bnep_pkg::ACCUM_MAX) : sum;
               end else if (point_seen) begin
                  shift_exp(-1);
               end
            end else if (b == bnep_pkg::CODE_POINT) begin
               if (mode != MODE_EXPO) point_seen = 1;
            end else if (b == bnep_pkg::CODE_EXP_ENTER) begin
               if (mode != MODE_EXPO) begin
                  mode  = MODE_EXPO;
                  accum = 0;
                  if (digits[0] == 4'd0) digits[0] = 4'd1;
               end
            end else begin
               if (mode == MODE_MANT) mant_neg = !mant_neg;
               else exp_neg = !exp_neg;
            end
            if (byte_count < int'(bnep_pkg::COUNT_MAX)) byte_count++;
         end else if (byte_count != 0) begin
            e = exp_neg ? run_exp - accum : run_exp + accum;
            n = '0;
            n.bytes_used = 8'(byte_count);
            if (e > lim || e < -lim) begin
               n.range_error = 1'b1;
            end else begin
               for (int i = 0; i < bnep_pkg::OUT_DIGITS && i < MANT_DIGITS; i++)
                  n.mant_bcd[(bnep_pkg::OUT_DIGITS - 1 - i) * 4 +: 4] = digits[i];
               n.mant_sign = mant_neg ? bnep_pkg::SIGN_NEG : bnep_pkg::SIGN_POS;
               n.exp_sign  = (e < 0) ? bnep_pkg::SIGN_NEG : bnep_pkg::SIGN_POS;
               mag         = (e < 0) ? -e : e;
               n.exp_bcd   = {4'(mag / 10), 4'(mag % 10)};
            end
            expected_numbers.push_back(n);
            clear();
         end
      endfunction

      function int pending();
         return expected_numbers.size();
      endfunction

      task report(string what);
         $display("mismatch at %0t: %s", $realtime, what);
         mismatches++;
      endtask

      task check_number(number_type got);
         number_type want;
         if (expected_numbers.size() == 0) begin
            report($sformatf("unexpected result %h", got));
            return;
         end
         want = expected_numbers.pop_front();
         if (got.range_error !== want.range_error)
            report($sformatf("range_error %0h, want %0h", got.range_error, want.range_error));
         if (got.mant_sign !== want.mant_sign)
            report($sformatf("mant_sign %0h, want %0h", got.mant_sign, want.mant_sign));
         if (got.mant_bcd !== want.mant_bcd)
            report($sformatf("mant_bcd %h, want %h", got.mant_bcd, want.mant_bcd));
         if (got.exp_sign !== want.exp_sign)
            report($sformatf("exp_sign %0h, want %0h", got.exp_sign, want.exp_sign));
         if (got.exp_bcd !== want.exp_bcd)
            report($sformatf("exp_bcd %h, want %h", got.exp_bcd, want.exp_bcd));
         if (got.bytes_used !== want.bytes_used)
            report($sformatf("bytes_used %0d, want %0d", got.bytes_used, want.bytes_used));
      endtask
   endclass

   logic        clock         = 1'b0;
   logic        reset         = 1'b1;
   logic        req_valid     = 1'b0;
   logic        req_stall;
   logic [7:0]  req_prog_byte = 8'h00;
   logic        rsp_valid;
   logic        rsp_stall     = 1'b0;
   logic        rsp_range_error;
   logic [3:0]  rsp_mant_sign;
   logic [39:0] rsp_mant_bcd;
   logic [3:0]  rsp_exp_sign;
   logic [7:0]  rsp_exp_bcd;
   logic [7:0]  rsp_bytes_used;

   bit              quiet       = 1'b0;
   int              items_sent  = 0;
   int              idle_cycles = 0;
   entry_scoreboard sb;

   bcd_number_entry_parser #(
      .MANT_DIGITS(MANT_DIGITS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_prog_byte(req_prog_byte),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_range_error(rsp_range_error),
      .rsp_mant_sign(rsp_mant_sign),
      .rsp_mant_bcd(rsp_mant_bcd),
      .rsp_exp_sign(rsp_exp_sign),
      .rsp_exp_bcd(rsp_exp_bcd),
      .rsp_bytes_used(rsp_bytes_used)
   );

   always #10 clock = ~clock;

   always @(negedge clock) begin
      rsp_stall <= !quiet && ($urandom_range(99) < IDLE_PCT);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_number({rsp_range_error, rsp_mant_sign, rsp_mant_bcd,
                          rsp_exp_sign, rsp_exp_bcd, rsp_bytes_used});
   end

   // count cycles in which neither channel moves an item
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
         $display("Verification failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   function automatic logic [7:0] digit_code(int d);
      return 8'(bnep_pkg::CODE_DIGIT_LO + 8'(d));
   endfunction

   function automatic logic [7:0] any_terminator();
      logic [7:0] b;
      do b = 8'($urandom_range(255));
      while (b >= bnep_pkg::CODE_DIGIT_LO && b <= bnep_pkg::CODE_CHG_SIGN);
      return b;
   endfunction

   // present one item, hold it until accepted
   task automatic send_byte(logic [7:0] b);
      @(negedge clock);
      while (!quiet && $urandom_range(99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_prog_byte <= b;
      do @(posedge clock); while (req_stall);
      sb.note_byte(b);
      items_sent++;
   endtask

   task automatic hold_until_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
   endtask

   task automatic send_number();
      int  kind;
      int  nz;
      int  nd;
      int  ne;
      int  pt_at;
      bit  pt_done;
      kind = $urandom_range(99);
      if (kind < 70) begin
         if ($urandom_range(9) < 2) send_byte(bnep_pkg::CODE_CHG_SIGN);
         pt_done = ($urandom_range(9) < 3);
         if (pt_done) send_byte(bnep_pkg::CODE_POINT);
         nz = $urandom_range(3);
         repeat (nz) send_byte(digit_code(0));
         nd = ($urandom_range(4) == 0) ? $urandom_range(14, 9) : $urandom_range(8);
         pt_at = (!pt_done && $urandom_range(1) == 1) ? $urandom_range(nd) : -1;
         for (int i = 0; i < nd; i++) begin
            if (i == pt_at) send_byte(bnep_pkg::CODE_POINT);
            send_byte(digit_code(i == 0 ? $urandom_range(9, 1) : $urandom_range(9)));
            if (i == 0 && $urandom_range(9) < 3) send_byte(bnep_pkg::CODE_CHG_SIGN);
         end
         if ($urandom_range(9) < 6) begin
            send_byte(bnep_pkg::CODE_EXP_ENTER);
            if ($urandom_range(9) < 4) send_byte(bnep_pkg::CODE_CHG_SIGN);
            ne = ($urandom_range(9) == 0) ? 4 : $urandom_range(3);
            repeat (ne) send_byte(digit_code($urandom_range(9)));
            if ($urandom_range(9) == 0) send_byte(bnep_pkg::CODE_POINT);
            if ($urandom_range(9) == 0) send_byte(bnep_pkg::CODE_CHG_SIGN);
         end
         send_byte(any_terminator());
      end else if (kind < 90) begin
         // entry codes in arbitrary order
         repeat ($urandom_range(12, 1))
            send_byte(8'($urandom_range(bnep_pkg::CODE_CHG_SIGN, bnep_pkg::CODE_DIGIT_LO)));
         send_byte(any_terminator());
      end else begin
         repeat ($urandom_range(8, 1)) send_byte(8'($urandom_range(255)));
      end
   endtask

   initial begin
      logic [7:0] directed [$];
      bit         paused;
      sb = new();
      paused = 0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      directed = '{
         8'h00,                                                    // nothing entered
         digit_code(1), bnep_pkg::CODE_POINT, digit_code(5), 8'hFF,
         bnep_pkg::CODE_POINT, digit_code(0), digit_code(0), digit_code(7), 8'h0F,
         digit_code(0), digit_code(3), 8'h1D,
         bnep_pkg::CODE_EXP_ENTER, bnep_pkg::CODE_CHG_SIGN, digit_code(9), digit_code(9),
         8'h80,
         bnep_pkg::CODE_CHG_SIGN, digit_code(9), bnep_pkg::CODE_CHG_SIGN,
         bnep_pkg::CODE_POINT, bnep_pkg::CODE_EXP_ENTER,
         bnep_pkg::CODE_POINT, digit_code(2), 8'h40
      };
      foreach (directed[i]) send_byte(directed[i]);
      hold_until_drained();

      while (items_sent < NUM_ITEMS) begin
         quiet = (items_sent >= 400 && items_sent < 700);
         if (!paused && items_sent >= 750) begin
            paused = 1;
            hold_until_drained();
         end
         send_number();
      end
      quiet = 0;

      // drive the byte count into saturation
      repeat (LONG_RUN) send_byte(digit_code($urandom_range(9, 1)));
      send_byte(bnep_pkg::CODE_EXP_ENTER);
      send_byte(bnep_pkg::CODE_CHG_SIGN);
      repeat (3) send_byte(digit_code(9));
      send_byte(any_terminator());
      send_byte(bnep_pkg::CODE_POINT);
      repeat (LONG_RUN) send_byte(digit_code(0));
      send_byte(bnep_pkg::CODE_EXP_ENTER);
      repeat (3) send_byte(digit_code(9));
      send_byte(any_terminator());
      repeat (65) begin
         send_byte(bnep_pkg::CODE_POINT);
         send_byte(bnep_pkg::CODE_CHG_SIGN);
      end
      send_byte(digit_code(5));
      send_byte(any_terminator());

      hold_until_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

// File: sim.f
sv/bnep_pkg.sv
sv/bnep_front.sv
sv/bnep_queue.sv
sv/bnep_exec.sv
sv/bnep_format.sv
sv/bcd_number_entry_parser.sv
tb/tb_top.sv
